>>> hdl/assert_macros.svh
// Assertion macros shared by the interrupt controller RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/ic72_pkg.sv
// Package for the 72-source interrupt controller: codes, register map,
// shortcut table, shared types and the priority helper. No dependencies.
`timescale 1ns / 1ps

package ic72_pkg;

   localparam int unsigned NUM_SOURCES = 72;
   localparam logic [9:0]  SPURIOUS    = 10'h3FF;

   // Transaction kinds; the unused code behaves as a sample
   typedef enum logic [1:0] {
      REQ_READ   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_SAMPLE = 2'd2
   } req_kind_type;

   // Register word indexes, in map order from offset 0x200
   localparam logic [3:0] REG_BASIC_PEND  = 4'd0;
   localparam logic [3:0] REG_PEND_LOW    = 4'd1;
   localparam logic [3:0] REG_PEND_HIGH   = 4'd2;
   localparam logic [3:0] REG_FIQ_CTRL    = 4'd3;
   localparam logic [3:0] REG_ENABLE_LOW  = 4'd4;
   localparam logic [3:0] REG_ENABLE_HIGH = 4'd5;
   localparam logic [3:0] REG_ENABLE_CORE = 4'd6;
   localparam logic [3:0] REG_DISABLE_LOW  = 4'd7;
   localparam logic [3:0] REG_DISABLE_HIGH = 4'd8;
   localparam logic [3:0] REG_DISABLE_CORE = 4'd9;

   // Peripheral sources mirrored into basic pending bits 10..20
   localparam int unsigned NUM_SHORTCUTS = 11;
   localparam logic [6:0] SHORTCUT_SRC [0:NUM_SHORTCUTS-1] = '{
      7'd7, 7'd9, 7'd10, 7'd18, 7'd19, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd62
   };

   // One accepted transaction
   typedef struct packed {
      logic [1:0]  req_kind;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
      logic [31:0] lines_low;
      logic [31:0] lines_high;
      logic [7:0]  lines_core;
   } item_type;

   // Enable masks and FIQ control
   typedef struct packed {
      logic [31:0] enable_low;
      logic [31:0] enable_high;
      logic [7:0]  enable_core;
      logic [7:0]  fiq_select;
   } ctrl_state_type;

   // One result
   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_out;
      logic        fiq_out;
      logic [9:0]  irq_number;
   } result_type;

   // Index of the lowest set bit: isolate it, then encode the one-hot word
   function automatic logic [4:0] low_index32(input logic [31:0] v);
      logic [31:0] iso;
      logic [4:0]  idx;
      iso = v & (~v + 32'd1);
      idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (iso[i]) begin
            idx = idx | 5'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> hdl/interrupt_controller_72_sources_unit.sv
// Interrupt controller for 64 peripheral and 8 core sources: top level.
// Depends on ic72_pkg, ic72_regs, ic72_decode and assert_macros.svh.
// Usage: each transaction (register read, register write or plain line sample)
// enters an input register, is decoded in one pass of combinational logic against
// the enable masks with its own write already applied, and lands in a result
// register. One transaction per clock is sustained while rsp_stall is low; a
// result reaches the rsp_ port from the result register, which it enters after
// the input register. The single decode stage between the two registers (the
// 32-bit priority encoders and the read mux) sets the clock period. A
// stalled result holds in its register while the input register still takes
// one more transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module interrupt_controller_72_sources_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_peripheral_lines_low,
   input  logic [31:0] req_peripheral_lines_high,
   input  logic [7:0]  req_core_lines,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_out,
   output logic        rsp_fiq_out,
   output logic [9:0]  rsp_irq_number
);
   import ic72_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   item_type       s1_item_ff, s1_item_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_data_ff, rsp_data_in;
   item_type       req_item;
   ctrl_state_type state_next;
   result_type     result;
   logic           advance;
   logic           accept;

   assign req_item = '{req_kind:   req_type,
                       reg_index:  req_reg_index,
                       write_data: req_write_data,
                       lines_low:  req_peripheral_lines_low,
                       lines_high: req_peripheral_lines_high,
                       lines_core: req_core_lines};

   // Handshake: move forward when the result register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   ic72_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (s1_item_ff),
      .state_next (state_next)
   );

   ic72_decode u_decode (
      .item   (s1_item_ff),
      .state  (state_next),
      .result (result)
   );

   // Next-state logic for both registers
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_item_in   = accept ? req_item : s1_item_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_data_in  = advance ? result : rsp_data_ff;
   end

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload flops
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff.read_data;
   assign rsp_irq_out    = rsp_data_ff.irq_out;
   assign rsp_fiq_out    = rsp_data_ff.fiq_out;
   assign rsp_irq_number = rsp_data_ff.irq_number;

   // A decoded number is reported exactly when something is pending
   `ASSERT_RST(a_spurious_iff_idle, clock, reset,
      rsp_valid_ff |-> ((rsp_data_ff.irq_number == SPURIOUS) == !rsp_data_ff.irq_out),
      "irq_number disagrees with irq_out")
   // A decoded number always names a real source
   `ASSERT_RST(a_number_in_range, clock, reset,
      (rsp_valid_ff && rsp_data_ff.irq_out) |-> (rsp_data_ff.irq_number < 10'(NUM_SOURCES)),
      "irq_number out of range")
   // Input is held off only when both registers are full and the output stalls
   `ASSERT_RST(a_stall_only_when_full, clock, reset,
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall),
      "request stalled without backpressure")
   // Reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!s1_valid_ff && !rsp_valid_ff),
      "pipeline not empty after reset")

endmodule

>>> hdl/ic72_regs.sv
// Enable mask and FIQ control registers with set/clear write decode.
// Depends on ic72_pkg.
`timescale 1ns / 1ps

module ic72_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ic72_pkg::item_type      item,
   output ic72_pkg::ctrl_state_type state_next
);
   import ic72_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   ctrl_state_type state_upd;

   // Apply this transaction's write, if any
   always_comb begin
      state_upd = state_ff;
      if (item.req_kind == REQ_WRITE) begin
         case (item.reg_index)
            REG_FIQ_CTRL:     state_upd.fiq_select  = item.write_data[7:0];
            REG_ENABLE_LOW:   state_upd.enable_low  = state_ff.enable_low | item.write_data;
            REG_ENABLE_HIGH:  state_upd.enable_high = state_ff.enable_high | item.write_data;
            REG_ENABLE_CORE:  state_upd.enable_core = state_ff.enable_core
                                                      | item.write_data[7:0];
            REG_DISABLE_LOW:  state_upd.enable_low  = state_ff.enable_low & ~item.write_data;
            REG_DISABLE_HIGH: state_upd.enable_high = state_ff.enable_high
                                                      & ~item.write_data;
            REG_DISABLE_CORE: state_upd.enable_core = state_ff.enable_core
                                                      & ~item.write_data[7:0];
            default:          state_upd = state_ff;
         endcase
      end
   end

   assign state_next = state_upd;

   // Commit only when the transaction moves to the result register
   always_comb begin
      state_in = advance ? state_upd : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/ic72_decode.sv
// Pending masks, basic pending word, priority decode, FIQ and read mux.
// Purely combinational; depends on ic72_pkg.
`timescale 1ns / 1ps

module ic72_decode (
   input  ic72_pkg::item_type       item,
   input  ic72_pkg::ctrl_state_type state,
   output ic72_pkg::result_type     result
);
   import ic72_pkg::*;

   logic [31:0] pend_low;
   logic [31:0] pend_high;
   logic [7:0]  pend_core;
   logic [63:0] pend_periph;
   logic [NUM_SHORTCUTS-1:0] shortcut;
   logic [NUM_SHORTCUTS-1:0] shortcut_first;
   logic [6:0]  shortcut_src;
   logic [31:0] basic;
   logic [71:0] raw_all;
   logic [6:0]  fiq_src;
   logic [9:0]  irq_number;
   logic [31:0] read_data;
   logic        irq_out;
   logic        fiq_out;

   // Pending is the raw line gated by its enable
   assign pend_low    = item.lines_low & state.enable_low;
   assign pend_high   = item.lines_high & state.enable_high;
   assign pend_core   = item.lines_core & state.enable_core;
   assign pend_periph = {pend_high, pend_low};

   // Shortcut copies and the first of them in bit order
   always_comb begin
      shortcut_src = '0;
      for (int i = 0; i < NUM_SHORTCUTS; i++) begin
         shortcut[i] = pend_periph[SHORTCUT_SRC[i][5:0]];
      end
      shortcut_first = shortcut & (~shortcut + 11'd1);
      for (int i = 0; i < NUM_SHORTCUTS; i++) begin
         if (shortcut_first[i]) begin
            shortcut_src = shortcut_src | SHORTCUT_SRC[i];
         end
      end
   end

   assign basic = {11'd0, shortcut, |pend_high, |pend_low, pend_core};

   // Priority: shortcuts, then low bank, high bank, core
   always_comb begin
      if (|shortcut) begin
         irq_number = {3'd0, shortcut_src};
      end else if (|pend_low) begin
         irq_number = {5'd0, low_index32(pend_low)};
      end else if (|pend_high) begin
         irq_number = 10'd32 + {5'd0, low_index32(pend_high)};
      end else if (|pend_core) begin
         irq_number = 10'd64 + {5'd0, low_index32({24'd0, pend_core})};
      end else begin
         irq_number = SPURIOUS;
      end
   end

   assign irq_out = (|pend_low) | (|pend_high) | (|pend_core);

   // FIQ follows the raw line of the selected source
   assign raw_all = {item.lines_core, item.lines_high, item.lines_low};
   assign fiq_src = state.fiq_select[6:0];
   assign fiq_out = state.fiq_select[7] && (fiq_src < 7'(NUM_SOURCES))
                    && raw_all[fiq_src];

   // Register read mux
   always_comb begin
      read_data = '0;
      if (item.req_kind == REQ_READ) begin
         case (item.reg_index)
            REG_BASIC_PEND:                    read_data = basic;
            REG_PEND_LOW:                      read_data = pend_low;
            REG_PEND_HIGH:                     read_data = pend_high;
            REG_FIQ_CTRL:                      read_data = {24'd0, state.fiq_select};
            REG_ENABLE_LOW, REG_DISABLE_LOW:   read_data = state.enable_low;
            REG_ENABLE_HIGH, REG_DISABLE_HIGH: read_data = state.enable_high;
            REG_ENABLE_CORE, REG_DISABLE_CORE: read_data = {24'd0, state.enable_core};
            default:                           read_data = '0;
         endcase
      end
   end

   assign result = '{read_data:  read_data,
                     irq_out:    irq_out,
                     fiq_out:    fiq_out,
                     irq_number: irq_number};

endmodule
